FILE: sv/cppj_pkg.sv
package cppj_pkg;

  // Screen size in pixels.
  localparam int SCREEN_WIDTH  = 1024;
  localparam int SCREEN_HEIGHT = 768;

  // 0.01 in Q4.60, rounded up, and 0.1 in Q16.16.
  localparam logic [63:0]        MIN_LEN_SQ = 64'd11529215046068470;
  localparam logic signed [34:0] DEPTH_MIN  = 35'sd6554;

  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  // Quotient bits of the perspective divider.
  localparam int DIV_STEPS = 34;

  typedef enum logic [2:0] {
    REG_POS_X    = 3'd0,
    REG_POS_Y    = 3'd1,
    REG_POS_Z    = 3'd2,
    REG_TGT_X    = 3'd3,
    REG_TGT_Y    = 3'd4,
    REG_TGT_Z    = 3'd5,
    REG_STRENGTH = 3'd6,
    REG_SCALE    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pix_x;
    logic signed [31:0] pix_y;
    logic signed [31:0] view_depth;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tgt_x;
    logic signed [31:0] tgt_y;
    logic signed [31:0] tgt_z;
    logic [30:0]        strength;
    logic [30:0]        scale;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] rgt_x;
    logic signed [31:0] rgt_y;
    logic signed [31:0] rgt_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
    logic signed [31:0] fwd_x;
    logic signed [31:0] fwd_y;
    logic signed [31:0] fwd_z;
  } basis_t;

  // Three-component vectors; element 0 is x.
  typedef logic [2:0][63:0] wvec_t;
  typedef logic [2:0][31:0] q30vec_t;

  // What travels beside the divider.
  typedef struct packed {
    logic               pen;
    logic               negx;
    logic               negy;
    logic [33:0]        magx;
    logic [33:0]        magy;
    logic signed [34:0] sz;
  } side_t;

endpackage

FILE: sv/cppj_norm.sv
module cppj_norm (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  cppj_pkg::wvec_t vec_in,
  output logic            done,
  output cppj_pkg::q30vec_t res
);
  import cppj_pkg::*;

  typedef enum logic [5:0] {
    N_IDLE  = 6'b000001,
    N_SCALE = 6'b000010,
    N_SQ    = 6'b000100,
    N_SQRT  = 6'b001000,
    N_DIV   = 6'b010000,
    N_DONE  = 6'b100000
  } nstate_t;

  nstate_t     state_r, state_nxt;
  logic [62:0] mag_r [3];
  logic [2:0]  neg_r;
  logic [1:0]  k_r;
  logic [61:0] prod_r;
  logic [63:0] acc_r;
  logic [63:0] root_r;
  logic [4:0]  j_r;
  logic [31:0] len_r;
  logic [32:0] rem_r;
  logic [30:0] quo_r;
  logic [4:0]  s_r;
  q30vec_t     res_r;

  logic [62:0] mx;
  logic [30:0] op;
  logic [63:0] bitv, trial, root_nxt, acc_sq_nxt;
  logic        sq_ge;
  logic [32:0] cur;
  logic        dv_ge;
  logic [30:0] quo_nxt;

  always_comb begin
    mx = (mag_r[0] > mag_r[1]) ? mag_r[0] : mag_r[1];
    if (mag_r[2] > mx) begin
      mx = mag_r[2];
    end
    case (k_r)
      2'd0:    op = mag_r[0][30:0];
      2'd1:    op = mag_r[1][30:0];
      2'd2:    op = mag_r[2][30:0];
      default: op = 31'd0;
    endcase
    // One step of the bitwise square root.
    bitv       = 64'd1 << {j_r, 1'b0};
    trial      = root_r + bitv;
    sq_ge      = acc_r >= trial;
    root_nxt   = sq_ge ? (root_r >> 1) + bitv : root_r >> 1;
    acc_sq_nxt = sq_ge ? acc_r - trial : acc_r;
    // One step of the restoring divider.
    cur     = (s_r == 5'd0) ? {2'b00, op} : {rem_r[31:0], 1'b0};
    dv_ge   = cur >= {1'b0, len_r};
    quo_nxt = {quo_r[29:0], dv_ge};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      N_IDLE: begin
        if (start) state_nxt = N_SCALE;
      end
      N_SCALE: begin
        if (mx == 63'd0) begin
          state_nxt = N_DONE;
        end else if (mx[62:31] == 32'd0 && mx[30]) begin
          state_nxt = N_SQ;
        end
      end
      N_SQ: begin
        if (k_r == 2'd3) state_nxt = N_SQRT;
      end
      N_SQRT: begin
        if (j_r == 5'd0) state_nxt = N_DIV;
      end
      N_DIV: begin
        if (s_r == 5'd30 && k_r == 2'd2) state_nxt = N_DONE;
      end
      N_DONE: state_nxt = N_IDLE;
      default: state_nxt = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      N_IDLE: begin
        if (start) begin
          for (int i = 0; i < 3; i++) begin
            neg_r[i] <= vec_in[i][63];
            mag_r[i] <= vec_in[i][63] ? 63'(-vec_in[i]) : vec_in[i][62:0];
          end
        end
      end
      N_SCALE: begin
        k_r <= 2'd0;
        if (mx == 63'd0) begin
          res_r <= '0;
        end else if (mx[62:31] != 32'd0) begin
          for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
        end else if (!mx[30]) begin
          for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
        end
      end
      N_SQ: begin
        prod_r <= 62'(op) * 62'(op);
        acc_r  <= (k_r == 2'd0) ? 64'd0 : acc_r + 64'(prod_r);
        k_r    <= k_r + 2'd1;
        root_r <= 64'd0;
        j_r    <= 5'd31;
      end
      N_SQRT: begin
        root_r <= root_nxt;
        acc_r  <= acc_sq_nxt;
        j_r    <= j_r - 5'd1;
        len_r  <= root_nxt[31:0];
        k_r    <= 2'd0;
        s_r    <= 5'd0;
      end
      N_DIV: begin
        rem_r <= dv_ge ? cur - {1'b0, len_r} : cur;
        quo_r <= quo_nxt;
        if (s_r == 5'd30) begin
          res_r[k_r] <= neg_r[k_r] ? -{1'b0, quo_nxt} : {1'b0, quo_nxt};
          s_r        <= 5'd0;
          k_r        <= k_r + 2'd1;
        end else begin
          s_r <= s_r + 5'd1;
        end
      end
      N_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign done = (state_r == N_DONE);
  assign res  = res_r;

endmodule

FILE: sv/cppj_basis.sv
module cppj_basis (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rebuild,
  input  cppj_pkg::cfg_t   cfg,
  output cppj_pkg::basis_t basis,
  output logic             busy
);
  import cppj_pkg::*;

  typedef enum logic [5:0] {
    B_IDLE  = 6'b000001,
    B_NORMF = 6'b000010,
    B_TEST  = 6'b000100,
    B_NORMR = 6'b001000,
    B_CROSS = 6'b010000,
    B_NORMU = 6'b100000
  } bstate_t;

  bstate_t            state_r, state_nxt;
  wvec_t              vec_r;
  logic               nstart_r;
  logic               pend_r;
  logic [2:0]         k_r;
  logic signed [31:0] f_r [3];
  logic signed [31:0] rn_r [3];
  logic signed [63:0] prod_r, lsq_r;
  logic signed [63:0] u0_r, u1_r, u2_r;
  basis_t             basis_r;

  logic               ndone;
  q30vec_t            nres;
  logic signed [31:0] mul_a, mul_b;
  logic [63:0]        lsq_sum;

  cppj_norm u_norm (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (nstart_r),
    .vec_in (vec_r),
    .done   (ndone),
    .res    (nres)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == B_TEST) begin
      mul_a = (k_r == 3'd0) ? f_r[2] : f_r[0];
      mul_b = mul_a;
    end else if (state_r == B_CROSS) begin
      case (k_r)
        3'd0:    begin mul_a = rn_r[1]; mul_b = f_r[2]; end
        3'd1:    begin mul_a = rn_r[2]; mul_b = f_r[1]; end
        3'd2:    begin mul_a = rn_r[2]; mul_b = f_r[0]; end
        3'd3:    begin mul_a = rn_r[0]; mul_b = f_r[2]; end
        3'd4:    begin mul_a = rn_r[0]; mul_b = f_r[1]; end
        3'd5:    begin mul_a = rn_r[1]; mul_b = f_r[0]; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
    lsq_sum = lsq_r + prod_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (rebuild || pend_r) state_nxt = B_NORMF;
      B_NORMF: if (ndone) state_nxt = B_TEST;
      B_TEST:  if (k_r == 3'd2) state_nxt = B_NORMR;
      B_NORMR: if (ndone) state_nxt = B_CROSS;
      B_CROSS: if (k_r == 3'd6) state_nxt = B_NORMU;
      B_NORMU: if (ndone) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      nstart_r <= 1'b0;
      pend_r   <= 1'b0;
      basis_r  <= '{rgt_x: -ONE_Q30, rgt_y: '0, rgt_z: '0,
                    up_x: '0, up_y: ONE_Q30, up_z: '0,
                    fwd_x: '0, fwd_y: '0, fwd_z: ONE_Q30};
    end else begin
      state_r  <= state_nxt;
      // A write that lands during a rebuild asks for one more, from the new values.
      if (state_r == B_IDLE) begin
        pend_r <= 1'b0;
      end else if (rebuild) begin
        pend_r <= 1'b1;
      end
      nstart_r <= (state_r == B_IDLE && (rebuild || pend_r)) ||
                  (state_r == B_TEST && k_r == 3'd2) ||
                  (state_r == B_CROSS && k_r == 3'd6);
      prod_r   <= 64'(mul_a) * 64'(mul_b);
      unique case (state_r)
        B_IDLE: begin
          if (rebuild || pend_r) begin
            vec_r[0] <= 64'(33'(cfg.tgt_x) - 33'(cfg.pos_x));
            vec_r[1] <= 64'(33'(cfg.tgt_y) - 33'(cfg.pos_y));
            vec_r[2] <= 64'(33'(cfg.tgt_z) - 33'(cfg.pos_z));
          end
        end
        B_NORMF: begin
          k_r <= 3'd0;
          if (ndone) begin
            for (int i = 0; i < 3; i++) f_r[i] <= nres[i];
          end
        end
        B_TEST: begin
          k_r   <= k_r + 3'd1;
          lsq_r <= prod_r;
          if (k_r == 3'd2) begin
            // Both sideways candidates have the same length, so a short one
            // falls straight through to the cross product with x.
            if (lsq_sum < MIN_LEN_SQ) begin
              vec_r[0] <= 64'd0;
              vec_r[1] <= -64'(f_r[2]);
              vec_r[2] <= 64'(f_r[1]);
            end else begin
              vec_r[0] <= -64'(f_r[2]);
              vec_r[1] <= 64'd0;
              vec_r[2] <= 64'(f_r[0]);
            end
          end
        end
        B_NORMR: begin
          k_r <= 3'd0;
          if (ndone) begin
            for (int i = 0; i < 3; i++) rn_r[i] <= nres[i];
          end
        end
        B_CROSS: begin
          k_r <= k_r + 3'd1;
          case (k_r)
            3'd1:    u0_r <= prod_r;
            3'd2:    u0_r <= u0_r - prod_r;
            3'd3:    u1_r <= prod_r;
            3'd4:    u1_r <= u1_r - prod_r;
            3'd5:    u2_r <= prod_r;
            3'd6: begin
              vec_r[0] <= u0_r;
              vec_r[1] <= u1_r;
              vec_r[2] <= u2_r - prod_r;
            end
            default: begin
            end
          endcase
        end
        B_NORMU: begin
          if (ndone) begin
            basis_r <= '{rgt_x: rn_r[0], rgt_y: rn_r[1], rgt_z: rn_r[2],
                         up_x: nres[0], up_y: nres[1], up_z: nres[2],
                         fwd_x: f_r[0], fwd_y: f_r[1], fwd_z: f_r[2]};
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign basis = basis_r;
  assign busy  = (state_r != B_IDLE) || pend_r;

endmodule

FILE: sv/cppj_div.sv
module cppj_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vin,
  input  logic [65:0]     num_x,
  input  logic [65:0]     num_y,
  input  logic [34:0]     den,
  input  cppj_pkg::side_t side_in,
  output logic            vout,
  output logic [33:0]     q_x,
  output logic [33:0]     q_y,
  output cppj_pkg::side_t side_out
);
  import cppj_pkg::*;

  logic [34:0] remx_r [DIV_STEPS];
  logic [34:0] remy_r [DIV_STEPS];
  logic [33:0] lowx_r [DIV_STEPS];
  logic [33:0] lowy_r [DIV_STEPS];
  logic [34:0] den_r  [DIV_STEPS];
  side_t       side_r [DIV_STEPS];
  logic        v_r    [DIV_STEPS];

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [34:0] rx_in, ry_in, d_in;
    logic [33:0] lx_in, ly_in;
    side_t       sd_in;
    logic        v_in;
    logic [35:0] cx, cy;
    logic        gx, gy;

    if (i == 0) begin : g_first
      // The upper bits are already below the divisor, as the quotient fits.
      assign rx_in = {3'b000, num_x[65:34]};
      assign ry_in = {3'b000, num_y[65:34]};
      assign lx_in = num_x[33:0];
      assign ly_in = num_y[33:0];
      assign d_in  = den;
      assign sd_in = side_in;
      assign v_in  = vin;
    end else begin : g_next
      assign rx_in = remx_r[i-1];
      assign ry_in = remy_r[i-1];
      assign lx_in = lowx_r[i-1];
      assign ly_in = lowy_r[i-1];
      assign d_in  = den_r[i-1];
      assign sd_in = side_r[i-1];
      assign v_in  = v_r[i-1];
    end

    assign cx = {rx_in, lx_in[33]};
    assign cy = {ry_in, ly_in[33]};
    assign gx = cx >= {1'b0, d_in};
    assign gy = cy >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        remx_r[i] <= gx ? 35'(cx - {1'b0, d_in}) : cx[34:0];
        remy_r[i] <= gy ? 35'(cy - {1'b0, d_in}) : cy[34:0];
        lowx_r[i] <= {lx_in[32:0], gx};
        lowy_r[i] <= {ly_in[32:0], gy};
        den_r[i]  <= d_in;
        side_r[i] <= sd_in;
      end
    end
  end

  assign vout     = v_r[DIV_STEPS-1];
  assign q_x      = lowx_r[DIV_STEPS-1];
  assign q_y      = lowy_r[DIV_STEPS-1];
  assign side_out = side_r[DIV_STEPS-1];

endmodule

FILE: sv/cppj_pipe.sv
module cppj_pipe #(
  parameter int SCREEN_W = cppj_pkg::SCREEN_WIDTH,
  parameter int SCREEN_H = cppj_pkg::SCREEN_HEIGHT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                accept,
  input  cppj_pkg::in_item_t  item,
  input  cppj_pkg::cfg_t      cfg,
  input  cppj_pkg::basis_t    basis,
  output logic                out_valid,
  output cppj_pkg::out_item_t out_item
);
  import cppj_pkg::*;

  // Screen centre in Q16.16.
  localparam logic signed [51:0] CENTRE_X = 52'(SCREEN_W * 32768);
  localparam logic signed [51:0] CENTRE_Y = 52'(SCREEN_H * 32768);

  function automatic logic [32:0] sat32(input logic signed [51:0] v);
    logic [32:0] r;
    if (v > 52'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -52'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  logic signed [31:0] b [3][3];
  logic signed [31:0] p [3];
  logic signed [31:0] pos [3];

  // Stage 1: offset from the camera.
  logic signed [32:0] t_r [3];
  logic               v1_r;
  // Stage 2: the nine products.
  logic signed [64:0] prd_r [3][3];
  logic               v2_r;
  // Stage 3: the three dot products.
  logic signed [66:0] dot_r [3];
  logic               v3_r;
  // Stage 4: rounded to Q16.16 as sign and magnitude.
  logic [33:0]        mag_r [3];
  logic [2:0]         neg_r;
  logic               v4_r;
  // Stage 5: divisor, enable and numerator products.
  logic [64:0]        pnx_r, pny_r;
  logic [34:0]        den5_r;
  side_t              sd5_r;
  logic               v5_r;
  // Stage 6: numerators.
  logic [65:0]        numx_r, numy_r;
  logic [34:0]        den6_r;
  side_t              sd6_r;
  logic               v6_r;
  // Stages after the divider.
  logic [64:0]        spx_r, spy_r;
  side_t              sd7_r;
  logic               v7_r;
  logic [49:0]        msx_r, msy_r;
  side_t              sd8_r;
  logic               v8_r;
  out_item_t          out_r;
  logic               vo_r;

  logic [66:0]        dabs [3];
  logic [66:0]        drnd [3];
  logic signed [34:0] sz4;
  logic               vd;
  logic [33:0]        qx, qy;
  side_t              sdd;
  logic [33:0]        vx, vy;
  logic [65:0]        rsx, rsy;
  logic signed [51:0] ax, ay, xw, yw;
  logic [32:0]        satx, saty, satz;

  assign b[0] = '{basis.rgt_x, basis.rgt_y, basis.rgt_z};
  assign b[1] = '{basis.up_x, basis.up_y, basis.up_z};
  assign b[2] = '{basis.fwd_x, basis.fwd_y, basis.fwd_z};
  assign p    = '{item.point_x, item.point_y, item.point_z};
  assign pos  = '{cfg.pos_x, cfg.pos_y, cfg.pos_z};

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dabs[j] = dot_r[j][66] ? 67'(-dot_r[j]) : 67'(dot_r[j]);
      drnd[j] = dabs[j] + (67'd1 << 29);
    end
    sz4 = neg_r[2] ? -$signed({1'b0, mag_r[2]}) : $signed({1'b0, mag_r[2]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= vd;
      v8_r <= v7_r;
      vo_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t_r[i] <= 33'(p[i]) - 33'(pos[i]);
      end
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          prd_r[j][i] <= 65'(t_r[i]) * 65'(b[j][i]);
        end
        dot_r[j] <= 67'(prd_r[j][0]) + 67'(prd_r[j][1]) + 67'(prd_r[j][2]);
        mag_r[j] <= drnd[j][63:30];
        neg_r[j] <= dot_r[j][66];
      end
      // Stage 5.
      pnx_r      <= 65'(mag_r[0]) * 65'(cfg.strength);
      pny_r      <= 65'(mag_r[1]) * 65'(cfg.strength);
      den5_r     <= 35'(cfg.strength) + 35'(sz4);
      sd5_r.pen  <= (cfg.strength != 31'd0) && (sz4 >= DEPTH_MIN);
      sd5_r.negx <= neg_r[0];
      sd5_r.negy <= neg_r[1];
      sd5_r.magx <= mag_r[0];
      sd5_r.magy <= mag_r[1];
      sd5_r.sz   <= sz4;
      // Stage 6: add half the divisor for rounding.
      numx_r <= 66'(pnx_r) + 66'(den5_r[34:1]);
      numy_r <= 66'(pny_r) + 66'(den5_r[34:1]);
      den6_r <= den5_r;
      sd6_r  <= sd5_r;
      // Pixel scale.
      spx_r <= 65'(vx) * 65'(cfg.scale);
      spy_r <= 65'(vy) * 65'(cfg.scale);
      sd7_r <= sdd;
      msx_r <= rsx[65:16];
      msy_r <= rsy[65:16];
      sd8_r <= sd7_r;
      out_r <= '{pix_x: satx[31:0], pix_y: saty[31:0], view_depth: satz[31:0],
                 saturated: satx[32] | saty[32] | satz[32]};
    end
  end

  cppj_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vin      (v6_r),
    .num_x    (numx_r),
    .num_y    (numy_r),
    .den      (den6_r),
    .side_in  (sd6_r),
    .vout     (vd),
    .q_x      (qx),
    .q_y      (qy),
    .side_out (sdd)
  );

  always_comb begin
    vx   = sdd.pen ? qx : sdd.magx;
    vy   = sdd.pen ? qy : sdd.magy;
    rsx  = 66'(spx_r) + 66'd32768;
    rsy  = 66'(spy_r) + 66'd32768;
    ax   = sd8_r.negx ? -$signed({2'b00, msx_r}) : $signed({2'b00, msx_r});
    ay   = sd8_r.negy ? -$signed({2'b00, msy_r}) : $signed({2'b00, msy_r});
    xw   = CENTRE_X + ax;
    yw   = CENTRE_Y - ay;
    satx = sat32(xw);
    saty = sat32(yw);
    satz = sat32(52'(sd8_r.sz));
  end

  assign out_valid = vo_r;
  assign out_item  = out_r;

endmodule

FILE: sv/camera_point_projection_core.sv
// Look-at camera projection. Each item is a world point (x, y, z) in signed
// Q16.16; each result gives its screen position in pixels (x to the right of
// the left edge, y down from the top edge, both Q16.16), its depth along the
// camera's forward axis and a flag that is set when any of the three had to be
// clipped to the 32-bit range. One result leaves for every item, in order.
// The screen size is set by the SCREEN_W and SCREEN_H parameters.
// The pipeline takes one item per clock while no output stall, register
// write or rebuild holds it; most of its stages are the 34-stage divider that
// applies the perspective factor f/(f+depth), one quotient bit per stage.
// Perspective applies only when the strength register is nonzero and the
// depth is at least 0.1. A stall on the output freezes the whole pipeline, so
// nothing is lost or repeated. The camera basis (right, up, forward, in Q2.30)
// is rebuilt from the position and target registers after every register
// write by a sequencer with a shared multiplier, a squarer, an iterative
// square root and a bit-serial divider. A zero vector, as when the target
// equals the position, skips the square root and the division, and a write
// that arrives during a rebuild queues one more rebuild from the latest
// values. The block takes no item until the basis is done. After reset the
// basis of the reset registers is loaded at once, with no rebuild. Registers
// should be written only while no item is in flight.
module camera_point_projection_core #(
  parameter int SCREEN_W = cppj_pkg::SCREEN_WIDTH,
  parameter int SCREEN_H = cppj_pkg::SCREEN_HEIGHT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cppj_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cppj_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);
  import cppj_pkg::*;

  cfg_t   cfg_r;
  logic   rebuild_r;
  basis_t basis;
  logic   busy;
  logic   en;
  logic   accept;

  // Configuration registers. Every write triggers a basis rebuild on the next
  // clock, once the new value is in place.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r     <= '{pos_x: '0, pos_y: '0, pos_z: -32'sd655360,
                     tgt_x: '0, tgt_y: '0, tgt_z: '0,
                     strength: 31'd655360, scale: 31'd65536};
      rebuild_r <= 1'b0;
    end else begin
      rebuild_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_POS_X:    cfg_r.pos_x    <= cfg_wdata;
          REG_POS_Y:    cfg_r.pos_y    <= cfg_wdata;
          REG_POS_Z:    cfg_r.pos_z    <= cfg_wdata;
          REG_TGT_X:    cfg_r.tgt_x    <= cfg_wdata;
          REG_TGT_Y:    cfg_r.tgt_y    <= cfg_wdata;
          REG_TGT_Z:    cfg_r.tgt_z    <= cfg_wdata;
          REG_STRENGTH: cfg_r.strength <= cfg_wdata[30:0];
          REG_SCALE:    cfg_r.scale    <= cfg_wdata[30:0];
          default: begin
          end
        endcase
      end
    end
  end

  cppj_basis u_basis (
    .clk     (clk),
    .rst_n   (rst_n),
    .rebuild (rebuild_r),
    .cfg     (cfg_r),
    .basis   (basis),
    .busy    (busy)
  );

  // The pipeline moves whenever the output register is empty or being taken.
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en || busy || rebuild_r || cfg_we;
  assign accept   = in_valid && !in_stall;

  cppj_pipe #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .accept    (accept),
    .item      (in_data),
    .cfg       (cfg_r),
    .basis     (basis),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the camera point projection core. A behavioural
// copy of the projection, kept in wide integer arithmetic, predicts every
// result at the moment its point is accepted. The checker compares each result
// that leaves the block with the oldest prediction, field by field.
module tb_top;
  import cppj_pkg::*;

  typedef logic signed [127:0] wide_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;

  camera_point_projection_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Our own copy of the register file and of the camera basis (Q2.30).
  longint          cam_pos [3];
  longint          look_at [3];
  longint unsigned strength;
  longint unsigned px_scale;
  longint          cam_right [3];
  longint          cam_up [3];
  longint          cam_fwd [3];

  out_item_t pending_results [$];
  int        mismatch_count;
  int        stall_pct;

  // 8 ns clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: generous compared with the slowest legal run, which is bounded
  // by the basis rebuilds and the receiver's stalls.
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag_of(input longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // Scales the magnitudes so the largest lies in [2^30, 2^31), then divides by
  // the integer square root of the sum of squares. A zero vector stays zero.
  function automatic void normalise(input longint c [3], output longint o [3]);
    longint unsigned m [3];
    longint unsigned mx;
    longint unsigned sum;
    longint unsigned len;
    longint unsigned q;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag_of(c[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      o = '{0, 0, 0};
      return;
    end
    while (mx >= 64'h8000_0000) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < 64'h4000_0000) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] << 30) / len;
      o[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic longint unsigned len_sq(input longint r [3]);
    return mag_of(r[0]) * mag_of(r[0]) + mag_of(r[1]) * mag_of(r[1]) +
           mag_of(r[2]) * mag_of(r[2]);
  endfunction

  // Right is forward x world up; when that is too short the fallbacks are up x
  // forward and then x-axis x forward. Up is right x forward.
  function automatic void rebuild_basis();
    longint d [3];
    longint f [3];
    longint r [3];
    longint rn [3];
    longint u [3];
    longint un [3];
    for (int i = 0; i < 3; i++) d[i] = look_at[i] - cam_pos[i];
    normalise(d, f);
    r = '{-f[2], 0, f[0]};
    if (len_sq(r) < MIN_LEN_SQ) begin
      r = '{f[2], 0, -f[0]};
      if (len_sq(r) < MIN_LEN_SQ) r = '{0, -f[2], f[1]};
    end
    normalise(r, rn);
    u[0] = rn[1] * f[2] - rn[2] * f[1];
    u[1] = rn[2] * f[0] - rn[0] * f[2];
    u[2] = rn[0] * f[1] - rn[1] * f[0];
    normalise(u, un);
    cam_right = rn;
    cam_up    = un;
    cam_fwd   = f;
  endfunction

  function automatic void store_register(input cfg_reg_t idx, input logic [31:0] v);
    case (idx)
      REG_POS_X:    cam_pos[0] = longint'($signed(v));
      REG_POS_Y:    cam_pos[1] = longint'($signed(v));
      REG_POS_Z:    cam_pos[2] = longint'($signed(v));
      REG_TGT_X:    look_at[0] = longint'($signed(v));
      REG_TGT_Y:    look_at[1] = longint'($signed(v));
      REG_TGT_Z:    look_at[2] = longint'($signed(v));
      REG_STRENGTH: strength   = longint'(v[30:0]);
      REG_SCALE:    px_scale   = longint'(v[30:0]);
      default: ;
    endcase
    rebuild_basis();
  endfunction

  // Dot product with one basis row, rounded from Q.46 to Q16.16, half away
  // from zero.
  function automatic wide_t camera_axis(input wide_t t [3], input longint row [3]);
    wide_t s;
    wide_t m;
    s = 0;
    for (int i = 0; i < 3; i++) s += t[i] * wide_t'(row[i]);
    m = (s < 0) ? -s : s;
    m = (m + (wide_t'(1) <<< 29)) >>> 30;
    return (s < 0) ? -m : m;
  endfunction

  function automatic wide_t mul_div_round(input wide_t v, input wide_t mul, input wide_t den);
    wide_t m;
    m = (v < 0) ? -v : v;
    m = (m * mul + den / 2) / den;
    return (v < 0) ? -m : m;
  endfunction

  function automatic logic [31:0] clip32(input wide_t v, inout logic flag);
    if (v > wide_t'(32'sh7fff_ffff)) begin
      flag = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < -(wide_t'(1) <<< 31)) begin
      flag = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic out_item_t predict_result(input in_item_t p);
    wide_t     t [3];
    wide_t     sx, sy, sz, x, y;
    logic      flag;
    out_item_t r;
    flag = 1'b0;
    t[0] = wide_t'(p.point_x) - wide_t'(cam_pos[0]);
    t[1] = wide_t'(p.point_y) - wide_t'(cam_pos[1]);
    t[2] = wide_t'(p.point_z) - wide_t'(cam_pos[2]);
    sx = camera_axis(t, cam_right);
    sy = camera_axis(t, cam_up);
    sz = camera_axis(t, cam_fwd);
    // Perspective only for a nonzero factor and a depth of at least 0.1.
    if (strength != 0 && sz >= wide_t'(DEPTH_MIN)) begin
      sx = mul_div_round(sx, wide_t'(strength), wide_t'(strength) + sz);
      sy = mul_div_round(sy, wide_t'(strength), wide_t'(strength) + sz);
    end
    // Pixel scale is Q16.16, so the product is rounded back down by 16 bits.
    x = wide_t'(SCREEN_WIDTH) * 32768 + mul_div_round(sx, wide_t'(px_scale), 65536);
    y = wide_t'(SCREEN_HEIGHT) * 32768 - mul_div_round(sy, wide_t'(px_scale), 65536);
    r.pix_x      = clip32(x, flag);
    r.pix_y      = clip32(y, flag);
    r.view_depth = clip32(sz, flag);
    r.saturated  = flag;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result %h", $realtime, out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.pix_x !== want.pix_x || out_data.pix_y !== want.pix_y ||
            out_data.view_depth !== want.view_depth ||
            out_data.saturated !== want.saturated) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: expected x=%h y=%h z=%h sat=%b, got x=%h y=%h z=%h sat=%b",
                     $realtime, want.pix_x, want.pix_y, want.view_depth,
                     want.saturated, out_data.pix_x, out_data.pix_y,
                     out_data.view_depth, out_data.saturated);
        end
      end
    end
  end

  // The receiver stalls at a rate that each test phase sets; zero gives
  // stretches where results flow out on every clock.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // ---------------------------------------------------------------------
  // Shared driving tasks; all of them start and end at a falling edge.
  // ---------------------------------------------------------------------

  // Presents one item and holds it until accepted. Valid is left high so that
  // the next item of a burst follows without a gap.
  task automatic send_point(input in_item_t p);
    in_valid = 1'b1;
    in_data  = p;
    do @(posedge clk); while (in_stall);
    pending_results.insert(pending_results.size(), predict_result(p));
    @(negedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Waits until every predicted result has been seen.
  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Registers are only written with nothing in flight.
  task automatic write_register(input cfg_reg_t idx, input logic [31:0] v);
    drain_results();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    store_register(idx, v);
  endtask

  task automatic set_camera(input logic [31:0] px, py, pz, tx, ty, tz);
    write_register(REG_POS_X, px);
    write_register(REG_POS_Y, py);
    write_register(REG_POS_Z, pz);
    write_register(REG_TGT_X, tx);
    write_register(REG_TGT_Y, ty);
    write_register(REG_TGT_Z, tz);
  endtask

  function automatic in_item_t make_point(input logic [31:0] x, y, z);
    in_item_t p;
    p.point_x = x;
    p.point_y = y;
    p.point_z = z;
    return p;
  endfunction

  // A coordinate that is small most of the time, so points land on screen,
  // and otherwise anywhere in the 32-bit range.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3, 4:    return $urandom_range(0, 32'h0fff_ffff) - 32'h0800_0000;
      default: return $urandom_range(0, 32'h01ff_ffff) - 32'h0100_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_factor();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'h7fff_ffff;
      2, 3:    return $urandom & 32'h7fff_ffff;
      default: return $urandom_range(32'h0000_4000, 32'h0020_0000);
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset configuration: camera at z = -10 looking at the origin.
  task automatic test_reset_camera();
    send_point(make_point(32'd0, 32'd0, 32'd0));
    send_point(make_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_point(make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_point(make_point(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000));
    // Points at the camera and just either side of the 0.1 depth threshold.
    send_point(make_point(32'h0001_0000, 32'h0001_0000, 32'hfff6_0000));
    send_point(make_point(32'h0002_0000, 32'hfffe_0000, 32'hfff6_0000 + 32'd6553));
    send_point(make_point(32'h0002_0000, 32'hfffe_0000, 32'hfff6_0000 + 32'd6554));
    send_point(make_point(32'h0003_0000, 32'h0005_0000, 32'hfff0_0000));
    pause_sender(0);
  endtask

  // Corner configurations: degenerate camera, looking straight up and down,
  // perspective disabled and the extremes of both factors.
  task automatic test_corner_cameras();
    set_camera(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
               32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    send_point(make_point(32'h0010_0000, 32'hfff0_0000, 32'h0020_0000));
    send_point(make_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    set_camera(32'd0, 32'd0, 32'd0, 32'd0, 32'h0005_0000, 32'd0);
    send_point(make_point(32'h0001_0000, 32'h0008_0000, 32'h0002_0000));
    send_point(make_point(32'hffff_0000, 32'h0001_0000, 32'hfffd_0000));
    set_camera(32'd0, 32'h0005_0000, 32'd0, 32'd0, 32'hfffb_0000, 32'd0);
    send_point(make_point(32'h0001_0000, 32'hfff0_0000, 32'h0002_0000));
    write_register(REG_STRENGTH, 32'd0);
    send_point(make_point(32'h0004_0000, 32'h0003_0000, 32'h0002_0000));
    set_camera(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    write_register(REG_STRENGTH, 32'h7fff_ffff);
    write_register(REG_SCALE, 32'h7fff_ffff);
    send_point(make_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    send_point(make_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    write_register(REG_SCALE, 32'd0);
    send_point(make_point(32'h1234_5678, 32'h8765_4321, 32'h7fff_ffff));
    write_register(REG_STRENGTH, 32'h0000_0001);
    write_register(REG_SCALE, 32'h0000_0001);
    send_point(make_point(32'h7fff_0000, 32'h8000_0000, 32'h0000_ffff));
    pause_sender(0);
  endtask

  // Random phases, each with its own camera, factors, idling and stall rate.
  task automatic test_random_phases(input int phases, input int per_phase);
    int sent;
    int burst;
    int gap;
    int max_gap;
    for (int ph = 0; ph < phases; ph++) begin
      if ($urandom_range(0, 3) == 0)
        set_camera(rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord(), rand_coord());
      else
        set_camera(rand_coord() >>> 4, rand_coord() >>> 4,
                   $urandom_range(0, 32'h00ff_ffff) - 32'h0140_0000,
                   rand_coord() >>> 6, rand_coord() >>> 6, rand_coord() >>> 6);
      write_register(REG_STRENGTH, rand_factor());
      write_register(REG_SCALE, rand_factor());
      stall_pct = (ph % 4 == 0) ? 0 : $urandom_range(5, 70);
      max_gap   = (ph % 4 == 0) ? 0 : $urandom_range(1, 10);
      sent = 0;
      while (sent < per_phase) begin
        burst = $urandom_range(1, 24);
        for (int i = 0; i < burst && sent < per_phase; i++) begin
          send_point(make_point(rand_coord(), rand_coord(), rand_coord()));
          sent++;
        end
        gap = $urandom_range(0, max_gap);
        if (gap != 0) pause_sender(gap);
        // Now and then let the pipeline empty completely before going on.
        if (sent >= per_phase / 2 && sent < per_phase / 2 + burst && ph % 2 == 1)
          drain_results();
      end
      pause_sender(0);
    end
  endtask

  initial begin
    int guard;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_index      = REG_POS_X;
    cfg_wdata      = '0;
    stall_pct      = 0;
    mismatch_count = 0;
    cam_pos  = '{0, 0, -655360};
    look_at  = '{0, 0, 0};
    strength = 655360;
    px_scale = 65536;
    rebuild_basis();

    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    stall_pct = 20;
    test_reset_camera();
    test_corner_cameras();
    test_random_phases(10, 68);

    // Let the last results come out, then wait on in case a stray result follows.
    in_valid = 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 200_000) begin
      @(negedge clk);
      guard++;
    end
    repeat (100) @(negedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
